FILE: rtl/core/aligned_multi_page_bump_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aligned multi-page bump allocator
// Shared concurrent assertion forms, clocked on clk, disabled under rst_n.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_MULTI_PAGE_BUMP_ALLOCATOR_UNIT_MACROS_SVH
`define ALIGNED_MULTI_PAGE_BUMP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define AMPBA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define AMPBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/ampba_pkg.sv
// ----------------------------------------------------------------------------
// ampba_pkg
// Field widths, default sizes and result codes of the bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ampba_pkg;

  // default page geometry
  localparam int PAGE_BYTES_DEF = 65536;
  localparam int MAX_PAGES_DEF  = 8;

  // fixed field widths
  localparam int CMD_W     = 1;
  localparam int SIZE_W    = 17;
  localparam int PAGE_ID_W = 3;
  localparam int OFFSET_W  = 16;
  localparam int STATUS_W  = 2;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // commands
  localparam cmd_t CMD_ALLOC = 1'b0;
  localparam cmd_t CMD_RESET = 1'b1;

  // result status
  localparam status_t ST_GRANTED = 2'd0;
  localparam status_t ST_RESET   = 2'd1;
  localparam status_t ST_ERROR   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/ampba_ram.sv
// ----------------------------------------------------------------------------
// ampba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ampba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ampba_rem_div.sv
// ----------------------------------------------------------------------------
// ampba_rem_div
// Restoring bit-serial remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ampba_rem_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,   // held stable while running
  output      logic             done,      // one-cycle pulse, rem valid and held
  output      logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r,  run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [DVD_W-1:0] dvd_r,  dvd_nxt;
  logic [DVS_W-1:0] rem_r,  rem_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one restoring step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DVD_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/core/aligned_multi_page_bump_allocator_unit.sv
// ----------------------------------------------------------------------------
// aligned_multi_page_bump_allocator_unit
// First-fit paged bump allocator with size-aligned block offsets.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------------
//  request  | in_cmd, in_req_size                           | start && !busy
//  result   | out_page_id, out_start_offset, out_status     | out_valid strobe
//
//  Reset commands, rejected sizes and the first allocation (no page open) give
//  their result in the cycle after the transfer.
//  Otherwise each open page walked takes a RAM read, a divider launch, the
//  remainder steps and a fit check; the bit-serial remainder unit dominates
//  this walk, and a request visits at most MAX_PAGES pages.
//  Fill levels live in the RAM; per-page valid flops make unwritten or reset
//  pages read as zero, so no clearing pass is needed after reset.
//  busy is high while a request is walked; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aligned_multi_page_bump_allocator_unit_macros.svh"

module aligned_multi_page_bump_allocator_unit #(
  parameter int PAGE_BYTES = ampba_pkg::PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = ampba_pkg::MAX_PAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [ampba_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [ampba_pkg::SIZE_W-1:0]   in_req_size,
  output      logic                           out_valid,
  output      logic [ampba_pkg::PAGE_ID_W-1:0] out_page_id,
  output      logic [ampba_pkg::OFFSET_W-1:0] out_start_offset,
  output      logic [ampba_pkg::STATUS_W-1:0] out_status
);

  localparam int SIZE_W = ampba_pkg::SIZE_W;
  localparam int FILL_W = $clog2(PAGE_BYTES + 1);
  localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PO_W   = $clog2(MAX_PAGES + 1);
  localparam int SUM_W  = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 2;
  localparam logic [SUM_W-1:0] PAGE_LIM = SUM_W'(PAGE_BYTES);
  localparam logic [PO_W-1:0]  PO_MAX   = PO_W'(MAX_PAGES);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_LAUNCH = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0]           state_r,     state_nxt;
  logic [PO_W-1:0]      pages_open_r, pages_open_nxt;
  logic [MAX_PAGES-1:0] valid_r,     valid_nxt;
  logic [IDX_W-1:0]     idx_r,       idx_nxt;
  logic [SIZE_W-1:0]    size_r,      size_nxt;
  logic [FILL_W-1:0]    fill_r,      fill_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     res_page_r,  res_page_nxt;
  logic [SUM_W-1:0]     res_off_r,   res_off_nxt;
  ampba_pkg::status_t   res_st_r,    res_st_nxt;

  // RAM ports
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [FILL_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [FILL_W-1:0] ram_rd_data;

  // remainder unit
  logic              div_go;
  logic              div_done;
  logic [SIZE_W-1:0] div_rem;

  // fit check on the current page
  logic [SUM_W-1:0]  size_ext;
  logic [SUM_W-1:0]  blk_start;
  logic [SUM_W-1:0]  blk_end;
  logic              blk_fit;
  logic              last_page;
  logic [IDX_W-1:0]  new_page;
  logic [SUM_W-1:0]  req_ext;
  logic              req_bad;

  ampba_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_PAGES)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  ampba_rem_div #(
    .DVD_W (FILL_W),
    .DVS_W (SIZE_W)
  ) u_rem_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (fill_nxt),
    .divisor  (size_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // request screening
  assign req_ext = SUM_W'(in_req_size);
  assign req_bad = (in_req_size == '0) || (req_ext > PAGE_LIM);

  // aligned block on the current page
  assign size_ext  = SUM_W'(size_r);
  assign blk_start = SUM_W'(fill_r) +
                     ((div_rem == '0) ? '0 : (size_ext - SUM_W'(div_rem)));
  assign blk_end   = blk_start + size_ext;
  assign blk_fit   = blk_end <= PAGE_LIM;
  assign last_page = (PO_W'(idx_r) + PO_W'(1)) == pages_open_r;
  assign new_page  = pages_open_r[IDX_W-1:0];

  // sequencer; the RAM is written only as a request finishes and read only
  // in a later request, so reads never overlap a write to the same entry
  always_comb begin
    state_nxt      = state_r;
    pages_open_nxt = pages_open_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = 1'b0;
    res_page_nxt   = res_page_r;
    res_off_nxt    = res_off_r;
    res_st_nxt     = res_st_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r;
    ram_wr_data    = blk_end[FILL_W-1:0];
    ram_rd_en      = 1'b0;
    div_go         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          res_page_nxt  = '0;
          res_off_nxt   = '0;
          size_nxt      = in_req_size;
          idx_nxt       = '0;
          priority if (in_cmd == ampba_pkg::CMD_RESET) begin
            valid_nxt  = '0;
            res_st_nxt = ampba_pkg::ST_RESET;
          end else if (req_bad) begin
            res_st_nxt = ampba_pkg::ST_ERROR;
          end else if (pages_open_r == '0) begin
            // first page opens with the block at offset zero
            ram_wr_en           = 1'b1;
            ram_wr_addr         = new_page;
            ram_wr_data         = req_ext[FILL_W-1:0];
            valid_nxt[new_page] = 1'b1;
            pages_open_nxt      = pages_open_r + PO_W'(1);
            res_page_nxt        = new_page;
            res_st_nxt          = ampba_pkg::ST_GRANTED;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_READ;
          end
        end
      end

      S_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = S_LAUNCH;
      end

      S_LAUNCH: begin
        // a page cleared by a reset command reads as empty
        fill_nxt  = valid_r[idx_r] ? ram_rd_data : '0;
        div_go    = 1'b1;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          priority if (blk_fit) begin
            ram_wr_en        = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            out_valid_nxt    = 1'b1;
            res_page_nxt     = idx_r;
            res_off_nxt      = blk_start;
            res_st_nxt       = ampba_pkg::ST_GRANTED;
            state_nxt        = S_IDLE;
          end else if (!last_page) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_READ;
          end else if (pages_open_r < PO_MAX) begin
            // no open page fits: open the next one
            ram_wr_en           = 1'b1;
            ram_wr_addr         = new_page;
            ram_wr_data         = size_ext[FILL_W-1:0];
            valid_nxt[new_page] = 1'b1;
            pages_open_nxt      = pages_open_r + PO_W'(1);
            out_valid_nxt       = 1'b1;
            res_page_nxt        = new_page;
            res_off_nxt         = '0;
            res_st_nxt          = ampba_pkg::ST_GRANTED;
            state_nxt           = S_IDLE;
          end else begin
            out_valid_nxt = 1'b1;
            res_page_nxt  = '0;
            res_off_nxt   = '0;
            res_st_nxt    = ampba_pkg::ST_ERROR;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pages_open_r <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_open_r <= pages_open_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    size_r     <= size_nxt;
    fill_r     <= fill_nxt;
    res_page_r <= res_page_nxt;
    res_off_r  <= res_off_nxt;
    res_st_r   <= res_st_nxt;
  end

  // result ports, masked to field widths
  logic [IDX_W+ampba_pkg::PAGE_ID_W-1:0] page_wide;
  logic [SUM_W+ampba_pkg::OFFSET_W-1:0]  off_wide;

  assign page_wide        = {{ampba_pkg::PAGE_ID_W{1'b0}}, res_page_r};
  assign off_wide         = {{ampba_pkg::OFFSET_W{1'b0}}, res_off_r};
  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_page_id      = page_wide[ampba_pkg::PAGE_ID_W-1:0];
  assign out_start_offset = off_wide[ampba_pkg::OFFSET_W-1:0];
  assign out_status       = res_st_r;

  // checks
  `AMPBA_ASSERT_NOW(a_res_when_idle, out_valid, !busy, "result while walking pages")
  `AMPBA_ASSERT_NEXT(a_req_progress, start && !busy, busy || out_valid, "request dropped")
  `AMPBA_ASSERT_NOW(a_pages_bound, 1'b1, pages_open_r <= PO_MAX, "page count overflow")
  `AMPBA_ASSERT_NEXT(a_wr_grants, ram_wr_en, out_valid && (out_status == ampba_pkg::ST_GRANTED), "fill write without grant")
  `AMPBA_ASSERT_NOW(a_div_in_walk, div_done, state_r == S_DIV, "remainder outside walk")

endmodule

`default_nettype wire
